>>> hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  // Root count codes.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned TOL_W  = 17;

  // Discriminant is below 2^65, so its square root fits in 33 bits.
  localparam int unsigned RAD_W     = 66;
  localparam int unsigned SQ_W      = 33;
  localparam int unsigned REM_W     = 37;
  localparam int unsigned SQ_STEPS  = 3;
  localparam int unsigned SQ_STAGES = SQ_W / SQ_STEPS;

  // Divider: 33 quotient bits, three per stage.
  localparam int unsigned DV_W      = 33;
  localparam int unsigned DV_STEPS  = 3;
  localparam int unsigned DV_STAGES = DV_W / DV_STEPS;

  // Numerators before the square root is folded in, and the divisor.
  typedef struct packed {
    logic [1:0]         cnt;
    logic signed [32:0] n1;
    logic signed [32:0] n2;
    logic signed [33:0] den;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SQ_W-1:0]  root;
  } sq_t;

  // One digit of the restoring square root.
  function automatic sq_t sq_step(sq_t st, logic [1:0] pair);
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    sq_t              r;
    acc   = {st.rem[REM_W-3:0], pair};
    trial = {{(REM_W-SQ_W-2){1'b0}}, st.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {st.root[SQ_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {st.root[SQ_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module qrs_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [qrs_pkg::TOL_W-1:0]           zero_tol_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0]   coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [qrs_pkg::RAD_W-1:0]           rad_o,
  output qrs_pkg::side_t                      side_o
);
  import qrs_pkg::*;

  function automatic logic [COEF_W-1:0] mag32(logic signed [COEF_W-1:0] x);
    return x[COEF_W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [2:0] v_q;
  logic [3:0] en;

  logic [TOL_W-1:0] tol;
  logic za_d, zb_d, zc_d;

  logic signed [31:0] a_q, b_q, c_q;
  logic               za_q, zb_q, zc_q;

  logic signed [63:0] bb_w, ac_w;
  logic [63:0]        bb_q;
  logic signed [63:0] ac_q;
  logic               quad_d, quad_q;
  side_t              side1_d, side1_q;

  logic signed [67:0] disc;
  logic [RAD_W-1:0]   rad_d, rad_q;
  side_t              side2_d, side2_q;

  logic signed [32:0] neg_b, neg_c;

  always_comb begin
    en[3] = !out_stall_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[2];
  assign rad_o       = rad_q;
  assign side_o      = side2_q;

  // A tolerance of zero behaves as one, so only an exact zero counts.
  assign tol  = (zero_tol_i == '0) ? TOL_W'(1) : zero_tol_i;
  assign za_d = mag32(coef_a_i) < {15'd0, tol};
  assign zb_d = mag32(coef_b_i) < {15'd0, tol};
  assign zc_d = mag32(coef_c_i) < {15'd0, tol};

  assign bb_w  = b_q * b_q;
  assign ac_w  = a_q * c_q;
  assign neg_b = -{b_q[31], b_q};
  assign neg_c = -{c_q[31], c_q};

  always_comb begin
    side1_d.cnt = CNT_NONE;
    side1_d.n1  = '0;
    side1_d.n2  = '0;
    side1_d.den = 34'sd1;
    quad_d      = 1'b0;
    if (za_q) begin
      if (zb_q) begin
        side1_d.cnt = zc_q ? CNT_INF : CNT_NONE;
      end else if (zc_q) begin
        side1_d.cnt = CNT_ONE;
      end else begin
        side1_d.cnt = CNT_ONE;
        side1_d.n1  = neg_c;
        side1_d.den = {{2{b_q[31]}}, b_q};
      end
    end else if (zc_q) begin
      if (zb_q) begin
        side1_d.cnt = CNT_ONE;
      end else begin
        side1_d.cnt = CNT_TWO;
        side1_d.n2  = neg_b;
        side1_d.den = {{2{a_q[31]}}, a_q};
      end
    end else begin
      quad_d      = 1'b1;
      side1_d.cnt = CNT_TWO;
      side1_d.n1  = neg_b;
      side1_d.n2  = neg_b;
      side1_d.den = {a_q[31], a_q, 1'b0};
    end
  end

  // Exact discriminant b*b - 4*a*c.
  assign disc = $signed({4'd0, bb_q}) - $signed({{2{ac_q[63]}}, ac_q, 2'b00});

  always_comb begin
    side2_d = side1_q;
    rad_d   = '0;
    if (quad_q) begin
      if (disc[67]) begin
        side2_d.cnt = CNT_NONE;
        side2_d.n1  = '0;
        side2_d.n2  = '0;
      end else begin
        rad_d = disc[RAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q  <= coef_a_i;
      b_q  <= coef_b_i;
      c_q  <= coef_c_i;
      za_q <= za_d;
      zb_q <= zb_d;
      zc_q <= zc_d;
    end
    if (en[1]) begin
      bb_q    <= bb_w;
      ac_q    <= ac_w;
      quad_q  <= quad_d;
      side1_q <= side1_d;
    end
    if (en[2]) begin
      rad_q   <= rad_d;
      side2_q <= side2_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [qrs_pkg::RAD_W-1:0]  rad_i,
  input  qrs_pkg::side_t             side_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [qrs_pkg::SQ_W-1:0]   root_o,
  output qrs_pkg::side_t             side_o
);
  import qrs_pkg::*;

  logic             v_q    [SQ_STAGES];
  logic [SQ_STAGES:0] en;
  logic [RAD_W-1:0] rad_q  [SQ_STAGES];
  logic [REM_W-1:0] rem_q  [SQ_STAGES];
  logic [SQ_W-1:0]  root_q [SQ_STAGES];
  side_t            side_q [SQ_STAGES];

  always_comb begin
    en[SQ_STAGES] = !out_stall_i;
    for (int k = SQ_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[SQ_STAGES-1];
  assign root_o      = root_q[SQ_STAGES-1];
  assign side_o      = side_q[SQ_STAGES-1];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic             v_in;
    logic [RAD_W-1:0] rad_in, rad_nx;
    logic [REM_W-1:0] rem_in;
    logic [SQ_W-1:0]  root_in;
    side_t            side_in;
    sq_t              st_nx;

    if (g == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      st_nx.rem  = rem_in;
      st_nx.root = root_in;
      rad_nx     = rad_in;
      for (int i = 0; i < SQ_STEPS; i++) begin
        st_nx  = sq_step(st_nx, rad_nx[RAD_W-1 -: 2]);
        rad_nx = rad_nx << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en[g]) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        rad_q[g]  <= rad_nx;
        rem_q[g]  <= st_nx.rem;
        root_q[g] <= st_nx.root;
        side_q[g] <= side_in;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/qrs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module qrs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [qrs_pkg::SQ_W-1:0]  root_i,
  input  qrs_pkg::side_t            side_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                root_count_o,
  output logic signed [31:0]        first_root_o,
  output logic signed [31:0]        second_root_o,
  output logic                      overflow_o
);
  import qrs_pkg::*;

  localparam int unsigned DV_N = DV_STAGES + 2;

  typedef struct packed {
    logic [DV_W:0]   rem;
    logic [DV_W-1:0] low;
    logic [DV_W-1:0] q;
    logic            big;
    logic            neg;
  } lane_t;

  function automatic lane_t lane_step(lane_t l, logic [DV_W-1:0] d);
    logic [DV_W:0] acc;
    lane_t         r;
    r     = l;
    acc   = {l.rem[DV_W-1:0], l.low[DV_W-1]};
    r.low = {l.low[DV_W-2:0], 1'b0};
    if (acc >= {1'b0, d}) begin
      r.rem = acc - {1'b0, d};
      r.q   = {l.q[DV_W-2:0], 1'b1};
    end else begin
      r.rem = acc;
      r.q   = {l.q[DV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Sets up one lane: magnitude of num * 2^16 split into the bits above the
  // quotient range (early overflow test) and the bits still to be shifted in.
  function automatic lane_t lane_init(logic signed [34:0] num, logic den_neg,
                                      logic [DV_W-1:0] d);
    logic [34:0] m;
    logic [50:0] n;
    lane_t       r;
    m     = num[34] ? (~num + 1'b1) : num;
    n     = {m[34:0], 16'd0};
    r.rem = {16'd0, n[50:33]};
    r.low = n[32:0];
    r.q   = '0;
    r.big = {15'd0, n[50:33]} >= d;
    r.neg = num[34] ^ den_neg;
    return r;
  endfunction

  // Applies the sign and saturates to the Q16.16 range: {overflow, value}.
  function automatic logic [32:0] sat_lane(lane_t l);
    logic [32:0] r;
    if (l.big) begin
      r = l.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end else if (l.neg) begin
      if (l.q > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else                       r = {1'b0, 32'((~l.q) + 1'b1)};
    end else begin
      if (l.q > 33'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                       r = {1'b0, l.q[31:0]};
    end
    return r;
  endfunction

  logic            v_q   [DV_N];
  logic [DV_N:0]   en;
  lane_t           l1_q  [DV_STAGES+1];
  lane_t           l2_q  [DV_STAGES+1];
  logic [DV_W-1:0] dm_q  [DV_STAGES+1];
  logic [1:0]      cnt_q [DV_STAGES+1];

  logic signed [34:0] num1, num2;
  logic [33:0]        den_abs;
  logic [32:0]        sat1, sat2;

  always_comb begin
    en[DV_N] = !out_stall_i;
    for (int k = DV_N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[DV_N-1];

  assign num1    = {{2{side_i.n1[32]}}, side_i.n1} + {2'b00, root_i};
  assign num2    = {{2{side_i.n2[32]}}, side_i.n2} - {2'b00, root_i};
  assign den_abs = side_i.den[33] ? (~side_i.den + 1'b1) : side_i.den;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      l1_q[0]  <= lane_init(num1, side_i.den[33], den_abs[DV_W-1:0]);
      l2_q[0]  <= lane_init(num2, side_i.den[33], den_abs[DV_W-1:0]);
      dm_q[0]  <= den_abs[DV_W-1:0];
      cnt_q[0] <= side_i.cnt;
    end
  end

  for (genvar g = 1; g <= DV_STAGES; g++) begin : g_stage
    lane_t l1_nx, l2_nx;

    always_comb begin
      l1_nx = l1_q[g-1];
      l2_nx = l2_q[g-1];
      for (int i = 0; i < DV_STEPS; i++) begin
        l1_nx = lane_step(l1_nx, dm_q[g-1]);
        l2_nx = lane_step(l2_nx, dm_q[g-1]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        l1_q[g]  <= l1_nx;
        l2_q[g]  <= l2_nx;
        dm_q[g]  <= dm_q[g-1];
        cnt_q[g] <= cnt_q[g-1];
      end
    end
  end

  assign sat1 = sat_lane(l1_q[DV_STAGES]);
  assign sat2 = sat_lane(l2_q[DV_STAGES]);

  always_ff @(posedge clk_i) begin
    if (en[DV_N-1]) begin
      root_count_o  <= cnt_q[DV_STAGES];
      first_root_o  <= sat1[31:0];
      second_root_o <= sat2[31:0];
      overflow_o    <= sat1[32] | sat2[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DV_N; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < DV_N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and returns a root count
// (0 none, 1 one, 2 two, 3 infinitely many), up to two Q16.16 roots and an overflow
// flag for saturated roots. The unit is a 27-stage pipeline that takes one transaction
// per clock when nothing stalls: three stages classify the coefficients and form the
// exact discriminant, eleven stages extract its square root three bits at a time, and
// thirteen stages divide both numerators in parallel three quotient bits a stage and
// saturate. A stall on the output freezes only the stages that hold data, so bubbles
// are squeezed out first. The zero_tolerance register (address 0) sets the magnitude
// below which a coefficient counts as zero; write it only while no transaction is in
// flight.
module quadratic_root_solver_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] coef_a_i,
  input  logic signed [31:0] coef_b_i,
  input  logic signed [31:0] coef_c_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         root_count_o,
  output logic signed [31:0] first_root_o,
  output logic signed [31:0] second_root_o,
  output logic               overflow_o
);
  import qrs_pkg::*;

  localparam logic REG_ZERO_TOL = 1'b0;

  logic [TOL_W-1:0] tol_q;

  logic             fr_valid, fr_stall;
  logic [RAD_W-1:0] fr_rad;
  side_t            fr_side;
  logic             sq_valid, sq_stall;
  logic [SQ_W-1:0]  sq_root;
  side_t            sq_side;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZERO_TOL) ? {15'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ZERO_TOL) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  qrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .zero_tol_i  (tol_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coef_a_i    (coef_a_i),
    .coef_b_i    (coef_b_i),
    .coef_c_i    (coef_c_i),
    .out_valid_o (fr_valid),
    .out_stall_i (fr_stall),
    .rad_o       (fr_rad),
    .side_o      (fr_side)
  );

  qrs_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_stall_o  (fr_stall),
    .rad_i       (fr_rad),
    .side_i      (fr_side),
    .out_valid_o (sq_valid),
    .out_stall_i (sq_stall),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  qrs_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (sq_valid),
    .in_stall_o    (sq_stall),
    .root_i        (sq_root),
    .side_i        (sq_side),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .root_count_o  (root_count_o),
    .first_root_o  (first_root_o),
    .second_root_o (second_root_o),
    .overflow_o    (overflow_o)
  );

`ifndef SYNTHESIS
  a_inf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o == CNT_INF |->
      first_root_o == 32'sd0 && second_root_o == 32'sd0 && !overflow_o)
    else $error("infinite-root result carries nonzero roots or overflow");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o == CNT_NONE |->
      first_root_o == 32'sd0 && second_root_o == 32'sd0 && !overflow_o)
    else $error("no-root result carries nonzero roots or overflow");

  a_one_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o == CNT_ONE |-> second_root_o == 32'sd0)
    else $error("one-root result has a nonzero second root");

  a_tol_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(tol_q))
    else $error("tolerance register changed without a write");
`endif

endmodule

`default_nettype wire
